@@ hw/rtl/hdrf_pkg.sv @@
// Package with shared types and constants for the HDRF edge partitioner.
package hdrf_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned VID_W      = 16;
  localparam int unsigned PART_OUT_W = 4;
  localparam int unsigned ACT_W      = 5;
  localparam int unsigned CAP_W      = 32;
  localparam int unsigned BW_W       = 16;
  localparam int unsigned EPS_W      = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Fractional bits of the balance weight.
  localparam int unsigned WEIGHT_FRAC = 8;

  // Saturation value of degree and load counters.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd3;

  // Register reset values.
  localparam logic [ACT_W-1:0] ACT_RST = 5'd16;
  localparam logic [CAP_W-1:0] CAP_RST = 32'hFFFF_FFFF;
  localparam logic [BW_W-1:0]  BW_RST  = 16'd282;
  localparam logic [EPS_W-1:0] EPS_RST = 8'd1;

  // Operand selection of the shared divider.
  typedef enum logic [1:0] {
    DIV_GAIN_U,
    DIV_GAIN_V,
    DIV_BAL
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr_en;
    logic     load_ids;
    logic     red_step;
    logic     rd_v;
    logic     wr_u;
    logic     wr_v;
    logic     scan_clr;
    logic     min_clr;
    logic     min_step;
    logic     scan_inc;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_gu;
    logic     cap_gv;
    logic     mul;
    logic     cmp;
    logic     commit_u;
    logic     commit_v;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic red_last;
    logic np_zero;
    logic scan_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/hdrf_edge_if.sv @@
// Request channel carrying one graph edge.
interface hdrf_edge_if;
  logic                          valid;
  logic                          ready;
  logic [hdrf_pkg::VID_W-1:0]    src_vertex;
  logic [hdrf_pkg::VID_W-1:0]    dst_vertex;

  modport source (output valid, output src_vertex, output dst_vertex, input ready);
  modport sink (input valid, input src_vertex, input dst_vertex, output ready);
endinterface

@@ hw/rtl/hdrf_part_if.sv @@
// Request channel carrying one partition assignment.
interface hdrf_part_if;
  logic                             valid;
  logic                             ready;
  logic [hdrf_pkg::PART_OUT_W-1:0]  chosen_partition;

  modport source (output valid, output chosen_partition, input ready);
  modport sink (input valid, input chosen_partition, output ready);
endinterface

@@ hw/rtl/hdrf_div.sv @@
// Bit-serial restoring divider for fixed point ratios num * 2^F / den, num <= den.
module hdrf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [hdrf_pkg::CNT_W-1:0]       num_i,
  input  logic [hdrf_pkg::CNT_W:0]         den_i,
  output logic                             done_o,
  output logic [FRAC_BITS:0]               quo_o
);

  localparam int unsigned RW  = hdrf_pkg::CNT_W + 2;
  localparam int unsigned CTW = $clog2(FRAC_BITS + 1);

  logic [RW-1:0]           rem_q;
  logic [hdrf_pkg::CNT_W:0] den_q;
  logic [FRAC_BITS:0]      quo_q;
  logic [CTW-1:0]          cnt_q;
  logic                    busy_q, done_q;
  logic                    ge;
  logic [RW-1:0]           rem_sub;

  // One quotient bit per cycle.
  assign ge      = rem_q >= RW'(den_q);
  assign rem_sub = ge ? (rem_q - RW'(den_q)) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CTW'(FRAC_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(num_i);
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_sub[RW-2:0], 1'b0};
      quo_q <= {quo_q[FRAC_BITS-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hw/rtl/hdrf_dp.sv @@
// Datapath: vertex stores, partition loads, scoring and result register.
module hdrf_dp #(
  parameter int unsigned MAX_VERTICES   = 65536,
  parameter int unsigned MAX_PARTITIONS = 16,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hdrf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hdrf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [hdrf_pkg::VID_W-1:0]          src_i,
  input  logic [hdrf_pkg::VID_W-1:0]          dst_i,
  input  hdrf_pkg::cmd_t                      cmd_i,
  output hdrf_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [hdrf_pkg::PART_OUT_W-1:0]     out_part_o
);

  localparam int unsigned VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned PW   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned NPW  = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned CW   = (NPW > hdrf_pkg::ACT_W) ? NPW : hdrf_pkg::ACT_W;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned GW   = FRAC_BITS + 2;
  localparam int unsigned PRW  = hdrf_pkg::BW_W + QW;
  localparam int unsigned SW   = FRAC_BITS + 10;
  localparam int unsigned DNW  = hdrf_pkg::CNT_W + 2;
  localparam int unsigned MW   = VW + 1 + hdrf_pkg::VID_W;
  localparam int unsigned IDW  = hdrf_pkg::VID_W;
  localparam int unsigned RCW  = $clog2(IDW);
  localparam logic [MW-1:0] MOD_V = MW'(MAX_VERTICES);
  localparam logic [VW-1:0] CLR_END = VW'(MAX_VERTICES - 1);
  localparam logic [GW-1:0] GAIN_TWO = GW'(2) << FRAC_BITS;

  // Configuration registers.
  logic [hdrf_pkg::ACT_W-1:0] act_q;
  logic [hdrf_pkg::CAP_W-1:0] cap_q;
  logic [hdrf_pkg::BW_W-1:0]  bw_q;
  logic [hdrf_pkg::EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= hdrf_pkg::ACT_RST;
      cap_q <= hdrf_pkg::CAP_RST;
      bw_q  <= hdrf_pkg::BW_RST;
      eps_q <= hdrf_pkg::EPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hdrf_pkg::CFG_ACTIVE:  act_q <= cfg_data_i[hdrf_pkg::ACT_W-1:0];
        hdrf_pkg::CFG_CAP:     cap_q <= cfg_data_i[hdrf_pkg::CAP_W-1:0];
        hdrf_pkg::CFG_WEIGHT:  bw_q  <= cfg_data_i[hdrf_pkg::BW_W-1:0];
        hdrf_pkg::CFG_EPSILON: eps_q <= cfg_data_i[hdrf_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of partitions in use, limited to the built maximum.
  logic [CW-1:0] np;
  assign np = (CW'(act_q) > CW'(MAX_PARTITIONS)) ? CW'(MAX_PARTITIONS) : CW'(act_q);

  // Vertex ids, reduced in place modulo the store depth.
  logic [IDW-1:0] src_q, dst_q;
  logic [RCW-1:0] red_q;
  logic [MW-1:0]  mod_sh;
  logic [VW-1:0]  au, av;

  assign mod_sh = MOD_V << red_q;
  assign au     = VW'(src_q);
  assign av     = VW'(dst_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ids) begin
      src_q <= src_i;
      dst_q <= dst_i;
      red_q <= RCW'(IDW - 1);
    end else if (cmd_i.red_step) begin
      if (MW'(src_q) >= mod_sh) src_q <= IDW'(MW'(src_q) - mod_sh);
      if (MW'(dst_q) >= mod_sh) dst_q <= IDW'(MW'(dst_q) - mod_sh);
      red_q <= red_q - 1'b1;
    end
  end

  // Clearing sweep address.
  logic [VW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_en) clr_q <= clr_q + 1'b1;
  end

  // Degree and replica stores, one write and one registered read per cycle.
  logic [hdrf_pkg::CNT_W-1:0]  deg_mem [MAX_VERTICES];
  logic [MAX_PARTITIONS-1:0]   rep_mem [MAX_VERTICES];
  logic [hdrf_pkg::CNT_W-1:0]  rd_deg_q, deg_inc;
  logic [MAX_PARTITIONS-1:0]   rd_rep_q, rep_u_q, rep_v_q, best_oh;
  logic [VW-1:0]               rd_addr;
  logic [PW-1:0]               best_q;

  assign rd_addr = cmd_i.rd_v ? av : au;
  assign deg_inc = (rd_deg_q == hdrf_pkg::CNT_MAX) ? rd_deg_q : rd_deg_q + 1'b1;
  assign best_oh = MAX_PARTITIONS'(1) << best_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      deg_mem[clr_q] <= '0;
      rep_mem[clr_q] <= '0;
    end else begin
      if (cmd_i.wr_u || cmd_i.wr_v) deg_mem[cmd_i.wr_v ? av : au] <= deg_inc;
      if (cmd_i.commit_u) rep_mem[au] <= rep_u_q | best_oh;
      else if (cmd_i.commit_v) rep_mem[av] <= rep_v_q | best_oh;
    end
    rd_deg_q <= deg_mem[rd_addr];
    rd_rep_q <= rep_mem[rd_addr];
  end

  // Bumped degrees and replica masks of both endpoints.
  logic [hdrf_pkg::CNT_W-1:0] du_q, dv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_u) begin
      du_q    <= deg_inc;
      rep_u_q <= rd_rep_q;
    end
    if (cmd_i.wr_v) begin
      dv_q    <= deg_inc;
      rep_v_q <= rd_rep_q;
      if (au == av) du_q <= deg_inc;
    end
  end

  // Partition loads, running peak and scan minimum.
  logic [hdrf_pkg::CNT_W-1:0] load_q [MAX_PARTITIONS];
  logic [hdrf_pkg::CNT_W-1:0] peak_q, min_q, load_p, load_b, load_b_inc;
  logic [PW-1:0]              p_q;

  assign load_p     = load_q[p_q];
  assign load_b     = load_q[best_q];
  assign load_b_inc = (load_b == hdrf_pkg::CNT_MAX) ? load_b : load_b + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) load_q[i] <= '0;
      peak_q <= '0;
    end else if (cmd_i.commit_v) begin
      load_q[best_q] <= load_b_inc;
      if (load_b_inc > peak_q) peak_q <= load_b_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_clr) min_q <= hdrf_pkg::CNT_MAX;
    else if (cmd_i.min_step && load_p < min_q) min_q <= load_p;
  end

  // Spread denominator shared by all partitions of one edge.
  logic [DNW-1:0] denom;
  logic           bal_zero;
  assign denom    = DNW'(eps_q) + DNW'(peak_q) - DNW'(min_q);
  assign bal_zero = (denom == '0) || (peak_q < load_p);

  // Shared divider and its operand selection.
  logic [hdrf_pkg::CNT_W-1:0] div_num;
  logic [hdrf_pkg::CNT_W:0]   div_den;
  logic [QW-1:0]              div_q;
  logic                       div_done;

  always_comb begin
    case (cmd_i.div_sel)
      hdrf_pkg::DIV_GAIN_U: begin
        div_num = du_q;
        div_den = (hdrf_pkg::CNT_W+1)'(du_q) + (hdrf_pkg::CNT_W+1)'(dv_q);
      end
      hdrf_pkg::DIV_GAIN_V: begin
        div_num = dv_q;
        div_den = (hdrf_pkg::CNT_W+1)'(du_q) + (hdrf_pkg::CNT_W+1)'(dv_q);
      end
      default: begin
        div_num = (peak_q >= load_p) ? peak_q - load_p : '0;
        div_den = (hdrf_pkg::CNT_W+1)'(denom);
      end
    endcase
  end

  hdrf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  // Replication gains and weighted balance product.
  logic [GW-1:0]  gu_q, gv_q;
  logic [PRW-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_gu) gu_q <= GAIN_TWO - GW'(div_q);
    if (cmd_i.cap_gv) gv_q <= GAIN_TWO - GW'(div_q);
    if (cmd_i.mul) prod_q <= PRW'(bw_q) * PRW'(bal_zero ? QW'(0) : div_q);
  end

  // Score of the current partition and best-so-far tracking.
  logic [SW-1:0] score, best_sc_q;
  assign score = (rep_u_q[p_q] ? SW'(gu_q) : SW'(0))
               + (rep_v_q[p_q] ? SW'(gv_q) : SW'(0))
               + SW'(prod_q >> hdrf_pkg::WEIGHT_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q       <= '0;
      best_q    <= '0;
      best_sc_q <= '0;
    end else if (cmd_i.scan_clr) begin
      p_q       <= '0;
      best_q    <= '0;
      best_sc_q <= '0;
    end else begin
      if (cmd_i.cmp && load_p < cap_q && score > best_sc_q) begin
        best_q    <= p_q;
        best_sc_q <= score;
      end
      if (cmd_i.scan_inc) p_q <= p_q + 1'b1;
    end
  end

  // Result register.
  logic                              out_valid_q;
  logic [hdrf_pkg::PART_OUT_W-1:0]   out_part_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit_v) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_v) out_part_q <= hdrf_pkg::PART_OUT_W'(best_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_part_o  = out_part_q;

  // Status toward the controller.
  assign sts_o.clr_last  = clr_q == CLR_END;
  assign sts_o.red_last  = red_q == '0;
  assign sts_o.np_zero   = np == '0;
  assign sts_o.scan_last = CW'(p_q) == np - 1'b1;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // A result is only written into a free result register.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_v |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // The divider never reports done right after a start.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> !div_done)
    else $error("divider done too early");

  // The peak load covers the load just bumped.
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_v |=> (peak_q >= load_q[best_q]))
    else $error("peak load below partition load");

endmodule

@@ hw/rtl/hdrf_ctrl.sv @@
// Controller state machine sequencing one edge through the datapath.
module hdrf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hdrf_pkg::sts_t  sts_i,
  output hdrf_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_REDUCE   = 5'd2;
  localparam logic [4:0] S_RD_U     = 5'd3;
  localparam logic [4:0] S_WR_U     = 5'd4;
  localparam logic [4:0] S_RD_V     = 5'd5;
  localparam logic [4:0] S_WR_V     = 5'd6;
  localparam logic [4:0] S_MIN      = 5'd7;
  localparam logic [4:0] S_GU_GO    = 5'd8;
  localparam logic [4:0] S_GU_WAIT  = 5'd9;
  localparam logic [4:0] S_GV_GO    = 5'd10;
  localparam logic [4:0] S_GV_WAIT  = 5'd11;
  localparam logic [4:0] S_BAL_GO   = 5'd12;
  localparam logic [4:0] S_BAL_WAIT = 5'd13;
  localparam logic [4:0] S_MUL      = 5'd14;
  localparam logic [4:0] S_CMP      = 5'd15;
  localparam logic [4:0] S_COMMIT_U = 5'd16;
  localparam logic [4:0] S_COMMIT_V = 5'd17;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = hdrf_pkg::DIV_BAL;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_ids = 1'b1;
          state_d        = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_last) state_d = S_RD_U;
      end
      S_RD_U: state_d = S_WR_U;
      S_WR_U: begin
        cmd_o.wr_u = 1'b1;
        state_d    = S_RD_V;
      end
      S_RD_V: begin
        cmd_o.rd_v = 1'b1;
        state_d    = S_WR_V;
      end
      S_WR_V: begin
        cmd_o.rd_v     = 1'b1;
        cmd_o.wr_v     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        cmd_o.min_clr  = 1'b1;
        state_d        = sts_i.np_zero ? S_COMMIT_U : S_MIN;
      end
      S_MIN: begin
        cmd_o.min_step = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_GU_GO;
        end
      end
      S_GU_GO: begin
        cmd_o.div_sel   = hdrf_pkg::DIV_GAIN_U;
        cmd_o.div_start = 1'b1;
        state_d         = S_GU_WAIT;
      end
      S_GU_WAIT: begin
        cmd_o.div_sel = hdrf_pkg::DIV_GAIN_U;
        if (sts_i.div_done) begin
          cmd_o.cap_gu = 1'b1;
          state_d      = S_GV_GO;
        end
      end
      S_GV_GO: begin
        cmd_o.div_sel   = hdrf_pkg::DIV_GAIN_V;
        cmd_o.div_start = 1'b1;
        state_d         = S_GV_WAIT;
      end
      S_GV_WAIT: begin
        cmd_o.div_sel = hdrf_pkg::DIV_GAIN_V;
        if (sts_i.div_done) begin
          cmd_o.cap_gv = 1'b1;
          state_d      = S_BAL_GO;
        end
      end
      S_BAL_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_BAL_WAIT;
      end
      S_BAL_WAIT: begin
        if (sts_i.div_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_COMMIT_U;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_BAL_GO;
        end
      end
      S_COMMIT_U: begin
        if (sts_i.out_free) begin
          cmd_o.commit_u = 1'b1;
          state_d        = S_COMMIT_V;
        end
      end
      S_COMMIT_V: begin
        cmd_o.commit_v = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

@@ hw/rtl/hdrf_edge_partitioner_top.sv @@
// Top level of the streaming HDRF edge partitioner.
// Each edge request (src_vertex, dst_vertex) yields one chosen_partition
// request. After reset the block sweeps its degree and replica stores clear,
// one vertex per cycle, and takes no edge until the sweep is done;
// configuration writes are taken at any time the block is idle. One edge at
// a time is processed. The processing time is set by the bit-serial divider,
// which computes both replication gains and then one balance ratio per
// partition in use, one quotient bit per cycle. A finished result waits in an
// output register, so the next edge is taken while it is still pending.
module hdrf_edge_partitioner_top #(
  parameter int unsigned MAX_VERTICES   = 65536,
  parameter int unsigned MAX_PARTITIONS = 16,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hdrf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hdrf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hdrf_edge_if.sink                       edge_i,
  hdrf_part_if.source                     part_o
);

  hdrf_pkg::cmd_t cmd;
  hdrf_pkg::sts_t sts;
  logic           in_ready;

  // Sequencer.
  hdrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(edge_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Stores, scoring and result register.
  hdrf_dp #(
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_PARTITIONS(MAX_PARTITIONS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .src_i      (edge_i.src_vertex),
    .dst_i      (edge_i.dst_vertex),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(part_o.ready),
    .out_valid_o(part_o.valid),
    .out_part_o (part_o.chosen_partition)
  );

  assign edge_i.ready = in_ready;

endmodule
